// ===== design/slrd_pkg.sv =====
// Shared types and constants for the sensor log record deframer
package slrd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int VALUE_W    = 33;
    localparam int SET_W      = 7;
    localparam int COLLECT_W  = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int RAW_W      = 16;
    localparam int SCALE_W    = 14;
    localparam int PROD_W     = RAW_W + SCALE_W;
    localparam int PROD_SHIFT = 6;

    localparam logic [SCALE_W-1:0]        TEMP_SCALE = 14'd12336;
    localparam logic signed [VALUE_W-1:0] TEMP_ADJ   = 33'sd3922002;
    localparam logic signed [VALUE_W-1:0] TEMP_MIN   = -33'sd3922002;
    localparam logic signed [VALUE_W-1:0] TEMP_MAX   = 33'sd8709869;

    typedef enum logic [2:0] {
        KIND_TIME  = 3'd0,
        KIND_ACC_X = 3'd1,
        KIND_ACC_Y = 3'd2,
        KIND_ACC_Z = 3'd3,
        KIND_TEMP  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  word;
    } t_field;

endpackage

// ===== design/slrd_front.sv =====
// Front end: header capture, field tracking and byte assembly
module slrd_front
    import slrd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_full,
    output logic              o_push,
    output t_field            o_entry
);

    logic                 r_header_seen;
    logic [SET_W-1:0]     r_set_size;
    logic [SET_W-1:0]     r_sample_count;
    t_kind                r_field_index;
    logic [1:0]           r_byte_pos;
    logic [COLLECT_W-1:0] r_collector;

    logic             accept;
    logic [1:0]       last_pos;
    logic             field_done;
    logic [SET_W-1:0] n_sample_count;
    t_kind            n_field_index;
    logic [SET_W-1:0] sc_inc;

    assign accept     = i_valid && !i_full;
    assign last_pos   = (r_field_index == KIND_TIME) ? 2'd3 : 2'd1;
    assign field_done = r_header_seen && (r_byte_pos >= last_pos);
    assign o_push     = accept && field_done;
    assign o_entry    = '{kind: r_field_index, word: {r_collector, i_in_byte}};
    assign sc_inc     = r_sample_count + 1'b1;

    always_comb begin
        n_sample_count = r_sample_count;
        n_field_index  = KIND_TIME;
        case (r_field_index)
            KIND_TIME:  n_field_index = KIND_ACC_X;
            KIND_ACC_X: n_field_index = KIND_ACC_Y;
            KIND_ACC_Y: n_field_index = KIND_ACC_Z;
            KIND_ACC_Z: begin
                if ((r_set_size != '0) && (sc_inc == r_set_size)) begin
                    n_sample_count = '0;
                    n_field_index  = KIND_TEMP;
                end else begin
                    n_sample_count = sc_inc;
                    n_field_index  = KIND_TIME;
                end
            end
            KIND_TEMP:  n_field_index = KIND_TIME;
            default:    n_field_index = KIND_TIME;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_seen  <= 1'b0;
            r_set_size     <= '0;
            r_sample_count <= '0;
            r_field_index  <= KIND_TIME;
            r_byte_pos     <= '0;
            r_collector    <= '0;
        end else if (accept) begin
            if (!r_header_seen) begin
                r_header_seen <= 1'b1;
                r_set_size    <= i_in_byte[BYTE_W-1] ? '0 : i_in_byte[SET_W-1:0];
            end else if (!field_done) begin
                r_collector <= {r_collector[COLLECT_W-BYTE_W-1:0], i_in_byte};
                r_byte_pos  <= r_byte_pos + 1'b1;
            end else begin
                r_collector    <= '0;
                r_byte_pos     <= '0;
                r_sample_count <= n_sample_count;
                r_field_index  <= n_field_index;
            end
        end
    end

endmodule

// ===== design/slrd_fifo.sv =====
// Short queue of assembled fields between front and back
module slrd_fifo
    import slrd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_field i_entry,
    input  logic   i_pop,
    output t_field o_entry,
    output logic   o_full,
    output logic   o_empty
);

    t_field                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_entry = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/slrd_back.sv =====
// Back end: temperature scaling, value formatting and output register
module slrd_back
    import slrd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_field                    i_entry,
    input  logic                      i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_field_kind,
    output logic signed [VALUE_W-1:0] o_field_value
);

    logic                      r_s1_valid;
    t_kind                     r_s1_kind;
    logic [WORD_W-1:0]         r_s1_word;
    logic [PROD_W-1:0]         r_s1_prod;
    logic                      r_out_valid;
    t_kind                     r_out_kind;
    logic signed [VALUE_W-1:0] r_out_value;

    logic                      out_load;
    logic                      s1_load;
    logic [RAW_W-1:0]          biased;
    logic signed [VALUE_W-1:0] n_out_value;

    assign out_load = !r_out_valid || !i_stall;
    assign s1_load  = !r_s1_valid || out_load;
    assign o_pop    = s1_load && !i_empty;
    assign biased   = i_entry.word[RAW_W-1:0] ^ {1'b1, {(RAW_W-1){1'b0}}};

    always_comb begin
        case (r_s1_kind)
            KIND_TIME:  n_out_value = $signed({1'b0, r_s1_word});
            KIND_ACC_X,
            KIND_ACC_Y,
            KIND_ACC_Z: n_out_value = $signed({{(VALUE_W-RAW_W){r_s1_word[RAW_W-1]}},
                                               r_s1_word[RAW_W-1:0]});
            KIND_TEMP:  n_out_value = $signed({{(VALUE_W-PROD_W+PROD_SHIFT){1'b0}},
                                               r_s1_prod[PROD_W-1:PROD_SHIFT]}) - TEMP_ADJ;
            default:    n_out_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind <= i_entry.kind;
            r_s1_word <= i_entry.word;
            r_s1_prod <= PROD_W'(biased) * PROD_W'(TEMP_SCALE);
        end
        if (out_load) begin
            r_out_kind  <= r_s1_kind;
            r_out_value <= n_out_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= !i_empty;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_field_kind  = r_out_kind;
    assign o_field_value = r_out_value;

endmodule

// ===== design/sensor_log_record_deframer.sv =====
// Sensor log record deframer top level: front end, field queue and back end
// Throughput: one byte per cycle unless the queue is full, one result per completed field.
// A result passes through the field queue, the back-end stage and the output register.
// The front end stalls only when the four-entry field queue is full.
// Reset (synchronous, active low) clears header, counters, queue and valid flags;
// the first byte after reset is taken as the set size.
module sensor_log_record_deframer
    import slrd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [BYTE_W-1:0]         i_in_byte,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_field_kind,
    output logic signed [VALUE_W-1:0] o_field_value
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_field front_entry;
    t_field head_entry;

    assign o_stall = full;

    slrd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_full    (full),
        .o_push    (push),
        .o_entry   (front_entry)
    );

    slrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    slrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_field_kind  (o_field_kind),
        .o_field_value (o_field_value)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("field pushed into full queue");

    a_time_unsigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_field_kind == KIND_TIME)) |-> !o_field_value[VALUE_W-1])
        else $error("timestamp not zero extended");

    a_accel_sext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_field_kind == KIND_ACC_X) || (o_field_kind == KIND_ACC_Y) ||
                     (o_field_kind == KIND_ACC_Z)))
        |-> ((o_field_value[VALUE_W-1:RAW_W-1] == '0) ||
             (o_field_value[VALUE_W-1:RAW_W-1] == '1)))
        else $error("acceleration not sign extended");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_field_kind == KIND_TEMP))
        |-> ((o_field_value >= TEMP_MIN) && (o_field_value <= TEMP_MAX)))
        else $error("temperature out of range");

endmodule
